@@ hdl/newton_square_root_signed_assert.svh @@
// Assertion macros shared by the square root block.
// Depends on nothing; taken in by the datapath, which checks its own logic.
`ifndef NEWTON_SQUARE_ROOT_SIGNED_ASSERT_SVH
`define NEWTON_SQUARE_ROOT_SIGNED_ASSERT_SVH

// Implication within the same cycle.
`define NSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsr check failed");

// Implication in the following cycle.
`define NSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsr check failed");

`endif

@@ hdl/nsr_pkg.sv @@
// Types and constants of the square root block.
// No dependencies; imported by controller, datapath and top level.
package nsr_pkg;

   localparam int ROOT_W = 24;
   localparam int STEP_W = 8;
   localparam int TOL_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [ROOT_W-1:0] ROOT_MAX = '1;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;
   localparam logic [STEP_W-1:0] CAP_RESET = 8'd40;

   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_CAP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } nsr_state_type;

   typedef struct packed {
      logic load;
      logic start_div;
      logic update;
      logic set_cap;
      logic finish;
   } nsr_cmd_type;

   typedef struct packed {
      logic is_zero;
      logic far;
      logic at_cap;
      logic div_done;
      logic out_free;
   } nsr_status_type;

endpackage

@@ hdl/nsr_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; used by the datapath for the Newton quotient.
module nsr_divider #(
   parameter int DIVIDEND_W = 47,
   parameter int DIVISOR_W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  busy,
   output logic                  done
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial = shifted - {1'b0, dvs_ff};
      fits = (shifted >= {1'b0, dvs_ff});
   end

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

@@ hdl/nsr_datapath.sv @@
// Datapath: operand magnitude, the two guesses, step count, divider,
// configuration registers and the result register. Depends on nsr_pkg, nsr_divider.
module nsr_datapath
   import nsr_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  nsr_cmd_type                 cmd,
   output nsr_status_type              status,
   input  logic signed [DATA_WIDTH-1:0] req_operand,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ROOT_W-1:0]           rsp_root,
   output logic                        rsp_imaginary,
   output logic [STEP_W-1:0]           rsp_steps_taken,
   output logic                        rsp_hit_cap
);
   `include "newton_square_root_signed_assert.svh"

   localparam int MW = DATA_WIDTH - 1;
   localparam int QW = MW + FRAC_BITS;
   localparam int EW = (DATA_WIDTH > ROOT_W) ? DATA_WIDTH : ROOT_W + 1;

   logic [TOL_W-1:0]      tol_ff, tol_in;
   logic [STEP_W-1:0]     cap_ff, cap_in;
   logic [MW-1:0]         mag_ff, mag_in;
   logic [DATA_WIDTH-1:0] est_ff, est_in;
   logic [DATA_WIDTH-1:0] prior_ff, prior_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  neg_ff, neg_in;
   logic                  capped_ff, capped_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic                  imag_ff, imag_in;
   logic [STEP_W-1:0]     steps_ff, steps_in;
   logic                  hit_ff, hit_in;

   logic [DATA_WIDTH-1:0] negated;
   logic [MW-1:0]         load_mag;
   logic [QW-1:0]         mag_q;
   logic [QW-1:0]         one_q;
   logic [DATA_WIDTH-1:0] start_guess;
   logic [DATA_WIDTH-1:0] diff;
   logic [QW-1:0]         quotient;
   logic [QW:0]           new_sum;
   logic [EW-1:0]         est_ext;
   logic                  div_busy;
   logic                  div_done;

   // Magnitude of the incoming operand, most negative value saturated.
   always_comb begin
      negated = ~req_operand + 1'b1;
      if (!req_operand[DATA_WIDTH-1]) begin
         load_mag = req_operand[MW-1:0];
      end else if (negated[DATA_WIDTH-1]) begin
         load_mag = '1;
      end else begin
         load_mag = negated[MW-1:0];
      end
      mag_q = QW'(load_mag);
      one_q = QW'(1) << FRAC_BITS;
      start_guess = DATA_WIDTH'(((mag_q > one_q) ? mag_q : one_q) >> 1);
   end

   always_comb begin
      diff = (est_ff > prior_ff) ? est_ff - prior_ff : prior_ff - est_ff;
      // floor((old + q) / 2) without a carry out of the word
      new_sum = (QW + 1)'(prior_ff >> 1) + (QW + 1)'(quotient >> 1)
              + (QW + 1)'(prior_ff[0] & quotient[0]);
      est_ext = EW'(est_ff);
   end

   nsr_divider #(
      .DIVIDEND_W (QW),
      .DIVISOR_W  (DATA_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (QW'(mag_ff) << FRAC_BITS),
      .divisor  (est_ff),
      .quotient (quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   always_comb begin
      tol_in = tol_ff;
      cap_in = cap_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_TOLERANCE: tol_in = csr_write_data;
            CSR_ITER_CAP:  cap_in = csr_write_data[STEP_W-1:0];
            default:       tol_in = tol_ff;
         endcase
      end
   end

   always_comb begin
      mag_in = mag_ff;
      est_in = est_ff;
      prior_in = prior_ff;
      step_in = step_ff;
      neg_in = neg_ff;
      capped_in = capped_ff;
      if (cmd.load) begin
         mag_in = load_mag;
         neg_in = req_operand[DATA_WIDTH-1];
         prior_in = DATA_WIDTH'(load_mag);
         est_in = (load_mag == '0) ? '0 : start_guess;
         step_in = '0;
         capped_in = 1'b0;
      end
      if (cmd.start_div) begin
         prior_in = est_ff;
      end
      if (cmd.update) begin
         est_in = DATA_WIDTH'(new_sum);
         step_in = step_ff + 1'b1;
      end
      if (cmd.set_cap) begin
         capped_in = 1'b1;
      end
   end

   // Result register: take a finished item, drop it once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      root_in = root_ff;
      imag_in = imag_ff;
      steps_in = steps_ff;
      hit_in = hit_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         root_in = (est_ext > EW'(ROOT_MAX)) ? ROOT_MAX : est_ext[ROOT_W-1:0];
         imag_in = neg_ff;
         steps_in = step_ff;
         hit_in = capped_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      est_ff <= est_in;
      prior_ff <= prior_in;
      step_ff <= step_in;
      neg_ff <= neg_in;
      capped_ff <= capped_in;
      root_ff <= root_in;
      imag_ff <= imag_in;
      steps_ff <= steps_in;
      hit_ff <= hit_in;
      if (reset) begin
         tol_ff <= TOL_RESET;
         cap_ff <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tol_ff <= tol_in;
         cap_ff <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      status.is_zero = (mag_ff == '0);
      status.far = (diff > DATA_WIDTH'(tol_ff));
      status.at_cap = (step_ff >= cap_ff);
      status.div_done = div_done;
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_root = root_ff;
   assign rsp_imaginary = imag_ff;
   assign rsp_steps_taken = steps_ff;
   assign rsp_hit_cap = hit_ff;

   `NSR_ASSERT_NOW(a_update_after_div, clock, reset, cmd.update, div_done)
   `NSR_ASSERT_NOW(a_div_start_idle, clock, reset, cmd.start_div, !div_busy)
   `NSR_ASSERT_NEXT(a_finish_shows, clock, reset, cmd.finish, rsp_valid_ff)
   `NSR_ASSERT_NOW(a_cap_count, clock, reset, rsp_valid_ff && hit_ff, steps_ff == cap_ff)

endmodule

@@ hdl/nsr_control.sv @@
// Controller state machine: sequences load, convergence checks, divisions
// and result hand-off. Depends on nsr_pkg.
module nsr_control
   import nsr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  nsr_status_type status,
   output nsr_cmd_type    cmd
);
   nsr_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.is_zero || !status.far) begin
               state_in = ST_FINISH;
            end else if (status.at_cap) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_CHECK: begin
            // stop when zero or converged, flag the cap, else run another division
            priority if (status.is_zero || !status.far) begin
               cmd = '0;
            end else if (status.at_cap) begin
               cmd.set_cap = 1'b1;
            end else begin
               cmd.start_div = 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.update = status.div_done;
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/newton_square_root_signed.sv @@
// Signed Newton-Raphson square root, top level.
// Channels: req_operand (signed Q16.16) in on req_valid/req_ready; the result
// (rsp_root Q8.16, rsp_imaginary, rsp_steps_taken, rsp_hit_cap) out on
// rsp_valid/rsp_ready. csr_write_en writes tolerance (index 0) or
// iteration_cap (index 1) from csr_write_data; write only while idle.
// A negative operand gives the root of its magnitude with rsp_imaginary set.
// From the accepting edge the controller runs a check state, then per Newton step
// one restoring division of DATA_WIDTH - 1 + FRAC_BITS quotient bits and an
// update, each followed by another check; finish loads the result register once
// it is free. A zero operand or an already converged guess goes from the first
// check straight to finish; the next item is taken once the controller is back in idle.
// One item is worked at a time; req_ready is high when no item is in work,
// also while a finished result waits in the output register.
// A stalled receiver holds the result register; a following item may run but
// its result waits until the register is taken.
// Reset (synchronous) restores tolerance 1 and iteration_cap 40 and empties
// the block.
module newton_square_root_signed
   import nsr_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_operand,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ROOT_W-1:0]            rsp_root,
   output logic                         rsp_imaginary,
   output logic [STEP_W-1:0]            rsp_steps_taken,
   output logic                         rsp_hit_cap,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);
   nsr_cmd_type    cmd;
   nsr_status_type status;

   nsr_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nsr_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operand     (req_operand),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_root        (rsp_root),
      .rsp_imaginary   (rsp_imaginary),
      .rsp_steps_taken (rsp_steps_taken),
      .rsp_hit_cap     (rsp_hit_cap)
   );

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the signed Newton-Raphson square root block.
// Depends on nsr_pkg and newton_square_root_signed; most results are compared
// with a cycle-free integer predictor of the same Newton iteration, typed rows with fixed values.
`timescale 1ns / 100ps

module tb;
   import nsr_pkg::*;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 9;
   localparam int TAIL_CYCLES = 120;
   localparam longint TIMEOUT_NS = 64'd200_000_000;
   localparam logic [63:0] ONE_Q16 = 64'd1 << FRAC_W;
   localparam logic [63:0] ROOT_CEIL = (64'd1 << ROOT_W) - 64'd1;
   localparam logic [63:0] MAG_LIMIT = 64'd1 << (DATA_W - 1);

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic              imaginary;
      logic [STEP_W-1:0] steps_taken;
      logic              hit_cap;
   } sqrt_result_t;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_TYPED,
      ROW_LIMITS
   } row_kind_e;

   typedef struct packed {
      row_kind_e         kind;
      logic [DATA_W-1:0] operand;
      logic [TOL_W-1:0]  tol;
      logic [STEP_W-1:0] cap;
      sqrt_result_t      typed;
   } stim_row_t;

   typedef struct packed {
      logic [TOL_W-1:0]  tol;
      logic [STEP_W-1:0] cap;
      int                items;
      int                send_idle_pct;
      int                stall_pct;
   } phase_t;

   localparam sqrt_result_t NO_RESULT = '0;

   // Directed part: default limits first, then a zero cap, a huge tolerance
   // and a zero tolerance, and back to the reset limits.
   localparam stim_row_t DIRECTED_ROWS [27] = '{
      '{ROW_TYPED,  32'h0000_0000, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h0000_0001, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'hFFFF_FFFF, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h0001_0000, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'hFFFF_0000, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h0004_0000, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h7FFF_FFFF, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h8000_0000, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h8000_0001, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h0000_FFFF, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h0002_0000, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h5555_5555, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'hAAAA_AAAA, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_LIMITS, 32'h0000_0000, 16'd1,     8'd0,   NO_RESULT},
      '{ROW_TYPED,  32'h0004_0000, 16'd0,     8'd0,   '{24'h02_0000, 1'b0, 8'd0, 1'b1}},
      '{ROW_TYPED,  32'h7FFF_FFFF, 16'd0,     8'd0,   '{24'hFF_FFFF, 1'b0, 8'd0, 1'b1}},
      '{ROW_TYPED,  32'h8000_0000, 16'd0,     8'd0,   '{24'hFF_FFFF, 1'b1, 8'd0, 1'b1}},
      '{ROW_TYPED,  32'h0000_0000, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_LIMITS, 32'h0000_0000, 16'hFFFF,  8'd255, NO_RESULT},
      '{ROW_TYPED,  32'h0001_0000, 16'd0,     8'd0,   '{24'h00_8000, 1'b0, 8'd0, 1'b0}},
      '{ROW_ITEM,   32'h7FFF_FFFF, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_TYPED,  32'hFFFF_0000, 16'd0,     8'd0,   '{24'h00_8000, 1'b1, 8'd0, 1'b0}},
      '{ROW_LIMITS, 32'h0000_0000, 16'd0,     8'd255, NO_RESULT},
      '{ROW_ITEM,   32'h0001_0000, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h7FFF_FFFF, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_ITEM,   32'h0000_0002, 16'd0,     8'd0,   NO_RESULT},
      '{ROW_LIMITS, 32'h0000_0000, TOL_RESET, CAP_RESET, NO_RESULT}
   };

   localparam phase_t PHASES [9] = '{
      '{16'd1,     8'd40,  400, 0,  0},
      '{16'd1,     8'd40,  350, 79, 0},
      '{16'd1,     8'd40,  150, 0,  79},
      '{16'hFFFF,  8'd255, 120, 31, 31},
      '{16'd0,     8'd20,  60,  0,  79},
      '{16'd0,     8'd255, 8,   0,  0},
      '{16'd7,     8'd8,   200, 31, 31},
      '{16'd3,     8'd1,   80,  79, 79},
      '{16'h0100,  8'd0,   40,  31, 31}
   };

   localparam logic [DATA_W-1:0] CORNER_OPERANDS [4] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_operand = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [ROOT_W-1:0]        rsp_root;
   logic                     rsp_imaginary;
   logic [STEP_W-1:0]        rsp_steps_taken;
   logic                     rsp_hit_cap;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_TOLERANCE;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;

   logic [TOL_W-1:0]  tol_setting = TOL_RESET;
   logic [STEP_W-1:0] cap_setting = CAP_RESET;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                error_count = 0;
   sqrt_result_t      awaited_roots[$];
   sqrt_result_t      oldest_root;

   newton_square_root_signed #(
      .DATA_WIDTH(DATA_W),
      .FRAC_BITS(FRAC_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operand(req_operand),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_root(rsp_root),
      .rsp_imaginary(rsp_imaginary),
      .rsp_steps_taken(rsp_steps_taken),
      .rsp_hit_cap(rsp_hit_cap),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Same Newton iteration on plain integers, under the current limits.
   function automatic sqrt_result_t predict_root(input logic [DATA_W-1:0] operand);
      logic [DATA_W-1:0] negated;
      logic [63:0]       magnitude;
      logic [63:0]       guess;
      logic [63:0]       last_guess;
      logic [63:0]       quotient;
      logic [63:0]       gap;
      logic              settled;
      sqrt_result_t      res;
      res = '0;
      res.imaginary = operand[DATA_W-1];
      negated = ~operand + 1'b1;
      magnitude = operand[DATA_W-1] ? {32'b0, negated} : {32'b0, operand};
      // the most negative operand has no positive twin: saturate
      if (magnitude == MAG_LIMIT) magnitude = MAG_LIMIT - 64'd1;
      guess = '0;
      if (magnitude != 0) begin
         last_guess = magnitude;
         guess = ((magnitude > ONE_Q16) ? magnitude : ONE_Q16) >> 1;
         settled = 1'b0;
         while (!settled) begin
            gap = (guess > last_guess) ? guess - last_guess : last_guess - guess;
            if (gap <= {48'b0, tol_setting}) begin
               settled = 1'b1;
            end else if (res.steps_taken >= cap_setting) begin
               res.hit_cap = 1'b1;
               settled = 1'b1;
            end else begin
               last_guess = guess;
               quotient = (last_guess == 0) ? '1 : (magnitude << FRAC_W) / last_guess;
               guess = (last_guess >> 1) + (quotient >> 1) + (last_guess & quotient & 64'd1);
               res.steps_taken = res.steps_taken + 1'b1;
            end
         end
      end
      res.root = (guess > ROOT_CEIL) ? ROOT_MAX : guess[ROOT_W-1:0];
      return res;
   endfunction

   task automatic offer_operand(input logic [DATA_W-1:0] operand,
                                input sqrt_result_t expected);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operand <= operand;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_roots.push_back(expected);
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      while (awaited_roots.size() != 0) @(posedge clock);
   endtask

   task automatic set_limits(input logic [TOL_W-1:0] tol, input logic [STEP_W-1:0] cap);
      await_drain();
      csr_write_en <= 1'b1;
      csr_index <= CSR_TOLERANCE;
      csr_write_data <= tol;
      @(posedge clock);
      csr_index <= CSR_ITER_CAP;
      csr_write_data <= cap;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tol_setting = tol;
      cap_setting = cap;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_roots.size() == 0) begin
               $error("root %0h arrived with no item awaiting it", rsp_root);
               error_count++;
            end else begin
               oldest_root = awaited_roots.pop_front();
               if (rsp_root !== oldest_root.root) begin
                  $error("root: expected %0h, got %0h", oldest_root.root, rsp_root);
                  error_count++;
               end
               if (rsp_imaginary !== oldest_root.imaginary) begin
                  $error("imaginary: expected %0b, got %0b",
                         oldest_root.imaginary, rsp_imaginary);
                  error_count++;
               end
               if (rsp_steps_taken !== oldest_root.steps_taken) begin
                  $error("steps_taken: expected %0d, got %0d",
                         oldest_root.steps_taken, rsp_steps_taken);
                  error_count++;
               end
               if (rsp_hit_cap !== oldest_root.hit_cap) begin
                  $error("hit_cap: expected %0b, got %0b", oldest_root.hit_cap, rsp_hit_cap);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   initial begin : stimulus
      stim_row_t         row;
      phase_t            phase;
      logic [DATA_W-1:0] operand;
      logic [DATA_W-1:0] shaped;
      int                pick;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         case (row.kind)
            ROW_LIMITS: set_limits(row.tol, row.cap);
            ROW_TYPED:  offer_operand(row.operand, row.typed);
            default:    offer_operand(row.operand, predict_root(row.operand));
         endcase
      end
      foreach (PHASES[p]) begin
         phase = PHASES[p];
         set_limits(phase.tol, phase.cap);
         send_idle_pct = phase.send_idle_pct;
         stall_pct = phase.stall_pct;
         for (int n = 0; n < phase.items; n++) begin
            // now and then hold off until the block has emptied
            if ($urandom_range(49, 0) == 0) await_drain();
            // random width keeps most items cheap while reaching full scale
            shaped = $urandom >> $urandom_range(DATA_W - 1, 0);
            pick = $urandom_range(99, 0);
            if (pick < 3) operand = '0;
            else if (pick < 7) operand = CORNER_OPERANDS[$urandom_range(3, 0)];
            else if (pick < 40) operand = -shaped;
            else operand = shaped;
            offer_operand(operand, predict_root(operand));
         end
      end
      await_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
